[rtl/ire_pkg.sv]
// Package for the interpolation registry engine.
// Holds sizes, codes, state type and the controller/datapath bundles; no dependencies.
package ire_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int OBJECT_COUNT  = 4096;
  localparam int KIND_COUNT    = 5;

  localparam int FUNC_W  = 3;
  localparam int KIND_W  = 3;
  localparam int OBJ_W   = 12;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 17;
  localparam int STAT_W  = 3;

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_COUNT = KIND_COUNT * OBJECT_COUNT;
  localparam int KEY_W     = $clog2(KEY_COUNT);
  localparam int EKEY_W    = KIND_W + OBJ_W;
  localparam int PAIR_W    = 2 * VAL_W;
  localparam int PROD_W    = VAL_W + FRAC_W + 1;
  localparam int FRAC_ONE  = 65536;
  localparam int FRAC_SH   = 16;

  localparam logic [KIND_W-1:0] KIND_FLOOR_PAN = KIND_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER     = 3'd0,
    FN_UNREGISTER   = 3'd1,
    FN_SET_CURRENT  = 3'd2,
    FN_TICK_CAPTURE = 3'd3,
    FN_RENDER_FRAME = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_IGNORED = 3'd1,
    ST_FULL    = 3'd2,
    ST_FRAME   = 3'd3,
    ST_EMPTY   = 3'd4
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SLOT, S_KEY, S_CHK, S_MV_RD, S_MV_WR, S_CLR,
    S_TK_RD, S_TK_WR, S_FR_RD, S_FR_MUL, S_FR_OUT, S_RES
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic latch;
    logic capture_slot;
    logic addr_idx;
    logic do_register;
    logic do_set;
    logic do_unreg;
    logic do_move;
    logic do_clear;
    logic tick_wr;
    logic idx_zero_ld;
    logic idx_top_ld;
    logic idx_inc;
    logic idx_dec;
    logic mul;
    logic load_frame;
    logic load_res;
    res_t res_status;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] func;
    logic              key_ok;
    logic              hit;
    logic              full;
    logic              cnt_zero;
    logic              move_need;
    logic              idx_last;
    logic              idx_zero;
    logic              out_free;
  } sts_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [KIND_W-1:0] kind,
                                              input logic [OBJ_W-1:0] obj);
    key_of = KEY_W'(KEY_W'(kind) * KEY_W'(OBJECT_COUNT)) + KEY_W'(obj);
  endfunction

endpackage

[rtl/ire_if.sv]
// Channel interfaces of the interpolation registry engine.
// Depends on ire_pkg for field widths.
interface ire_in_if;
  import ire_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [KIND_W-1:0]        kind;
  logic [OBJ_W-1:0]         object_index;
  logic signed [VAL_W-1:0]  value_a;
  logic signed [VAL_W-1:0]  value_b;
  logic [FRAC_W-1:0]        frac;
  modport source(output valid, func, kind, object_index, value_a, value_b, frac,
                 input ready);
  modport sink(input valid, func, kind, object_index, value_a, value_b, frac,
               output ready);
endinterface

interface ire_out_if;
  import ire_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [KIND_W-1:0]        out_kind;
  logic [OBJ_W-1:0]         out_object;
  logic signed [VAL_W-1:0]  interp_a;
  logic signed [VAL_W-1:0]  interp_b;
  logic                     last;
  modport source(output valid, status, out_kind, out_object, interp_a, interp_b, last,
                 input ready);
  modport sink(input valid, status, out_kind, out_object, interp_a, interp_b, last,
               output ready);
endinterface

interface ire_cfg_if;
  logic valid;
  logic ready;
  logic interp_enable;
  modport source(output valid, interp_enable, input ready);
  modport sink(input valid, interp_enable, output ready);
endinterface

[rtl/ire_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ire_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/ire_ctrl.sv]
// Sequencer of the interpolation registry engine.
// Depends on ire_pkg; drives cmd_t to ire_dp and reads sts_t back.
module ire_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  ire_pkg::sts_t sts,
  output ire_pkg::cmd_t cmd
);
  import ire_pkg::*;

  state_t state_r, state_nxt;
  res_t   st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = st_r;
    state_nxt      = state_r;
    st_nxt         = st_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func) inside
          FN_REGISTER, FN_UNREGISTER, FN_SET_CURRENT: state_nxt = S_SLOT;
          FN_TICK_CAPTURE: begin
            st_nxt = ST_DONE;
            if (sts.cnt_zero) begin
              state_nxt = S_RES;
            end else begin
              cmd.idx_zero_ld = 1'b1;
              state_nxt       = S_TK_RD;
            end
          end
          FN_RENDER_FRAME: begin
            if (sts.cnt_zero) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RES;
            end else begin
              cmd.idx_top_ld = 1'b1;
              state_nxt      = S_FR_RD;
            end
          end
          default: begin
            st_nxt    = ST_IGNORED;
            state_nxt = S_RES;
          end
        endcase
      end
      S_SLOT: state_nxt = S_KEY;
      S_KEY: begin
        cmd.capture_slot = 1'b1;
        state_nxt        = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_RES;
        st_nxt    = ST_IGNORED;
        case (sts.func)
          FN_REGISTER: begin
            if (!sts.key_ok || sts.hit) begin
              st_nxt = ST_IGNORED;
            end else if (sts.full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.do_register = 1'b1;
              st_nxt          = ST_DONE;
            end
          end
          FN_SET_CURRENT: begin
            if (sts.hit) begin
              cmd.do_set = 1'b1;
              st_nxt     = ST_DONE;
            end
          end
          FN_UNREGISTER: begin
            if (sts.hit) begin
              cmd.do_unreg = 1'b1;
              st_nxt       = ST_DONE;
              state_nxt    = sts.move_need ? S_MV_RD : S_CLR;
            end
          end
          default: st_nxt = ST_IGNORED;
        endcase
      end
      S_MV_RD: begin
        cmd.addr_idx = 1'b1;
        state_nxt    = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.addr_idx = 1'b1;
        cmd.do_move  = 1'b1;
        state_nxt    = S_CLR;
      end
      S_CLR: begin
        cmd.do_clear = 1'b1;
        state_nxt    = S_RES;
      end
      S_TK_RD: begin
        cmd.addr_idx = 1'b1;
        state_nxt    = S_TK_WR;
      end
      S_TK_WR: begin
        cmd.addr_idx = 1'b1;
        cmd.tick_wr  = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_RES;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_TK_RD;
        end
      end
      S_FR_RD: begin
        cmd.addr_idx = 1'b1;
        state_nxt    = S_FR_MUL;
      end
      S_FR_MUL: begin
        cmd.addr_idx = 1'b1;
        cmd.mul      = 1'b1;
        state_nxt    = S_FR_OUT;
      end
      S_FR_OUT: begin
        cmd.addr_idx = 1'b1;
        if (sts.out_free) begin
          cmd.load_frame = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = S_FR_RD;
          end
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[rtl/ire_dp.sv]
// Datapath of the interpolation registry engine: input hold, table memories,
// slot map, blend multipliers and the result register. Depends on ire_pkg, ire_if, ire_ram.
module ire_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  ire_pkg::cmd_t cmd,
  output ire_pkg::sts_t sts,
  ire_in_if.sink        in_if,
  ire_out_if.source     out_if,
  ire_cfg_if.sink       cfg_if
);
  import ire_pkg::*;

  logic [FUNC_W-1:0] func_r;
  logic [KIND_W-1:0] kind_r;
  logic [OBJ_W-1:0]  obj_r;
  logic [VAL_W-1:0]  va_r, vb_r, vbm;
  logic [FRAC_W-1:0] frac_r;
  logic              enable_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r, hole_r, tbl_raddr, last_idx;
  logic              slot_ok_r;
  logic [KEY_W-1:0]  key_w;
  logic              key_ok;

  logic              slot_we;
  logic [KEY_W-1:0]  slot_waddr;
  logic [CNT_W-1:0]  slot_wdata, slot_rd;
  logic              key_we, old_we, cur_we;
  logic [IDX_W-1:0]  key_waddr, old_waddr, cur_waddr;
  logic [EKEY_W-1:0] key_wdata, key_rd;
  logic [PAIR_W-1:0] old_wdata, cur_wdata, old_rd, cur_rd;

  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic [VAL_W-1:0]  da, db, res_a, res_b;

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [KIND_W-1:0] okind_r;
  logic [OBJ_W-1:0]  oobj_r;
  logic [VAL_W-1:0]  oa_r, ob_r;
  logic              olast_r;
  logic              out_free;

  assign in_if.ready  = cmd.in_ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_if.valid) begin
      enable_r <= cfg_if.interp_enable;
    end
  end

  // Hold the accepted transaction; saturate frac to one whole tic.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_if.func;
      kind_r <= in_if.kind;
      obj_r  <= in_if.object_index;
      va_r   <= in_if.value_a;
      vb_r   <= in_if.value_b;
      frac_r <= (32'(in_if.frac) > FRAC_ONE) ? FRAC_W'(FRAC_ONE) : in_if.frac;
    end
  end

  assign key_w    = key_of(kind_r, obj_r);
  assign key_ok   = (32'(kind_r) < KIND_COUNT) && (32'(obj_r) < OBJECT_COUNT);
  assign vbm      = (kind_r >= KIND_FLOOR_PAN) ? vb_r : '0;
  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture_slot) begin
      slot_ok_r <= (slot_rd != '0) && (slot_rd <= count_r);
      hole_r    <= IDX_W'(slot_rd - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.do_register) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.do_unreg) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.idx_zero_ld) begin
        idx_r <= '0;
      end else if (cmd.idx_top_ld || cmd.do_unreg) begin
        idx_r <= last_idx;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - IDX_W'(1);
      end
    end
  end

  assign tbl_raddr = cmd.addr_idx ? idx_r : IDX_W'(slot_rd - CNT_W'(1));

  // Write port steering for each store.
  always_comb begin
    slot_we    = cmd.do_register || cmd.do_move || cmd.do_clear;
    slot_waddr = cmd.do_move ? key_of(key_rd[EKEY_W-1:OBJ_W], key_rd[OBJ_W-1:0]) : key_w;
    slot_wdata = cmd.do_register ? count_r + CNT_W'(1) :
                 cmd.do_move     ? CNT_W'(hole_r) + CNT_W'(1) : '0;
    key_we     = cmd.do_register || cmd.do_move;
    key_waddr  = cmd.do_register ? IDX_W'(count_r) : hole_r;
    key_wdata  = cmd.do_register ? {kind_r, obj_r} : key_rd;
    old_we     = cmd.do_register || cmd.do_move || cmd.tick_wr;
    old_waddr  = cmd.do_register ? IDX_W'(count_r) : cmd.do_move ? hole_r : idx_r;
    old_wdata  = cmd.do_register ? {va_r, vbm} : cmd.do_move ? old_rd : cur_rd;
    cur_we     = cmd.do_register || cmd.do_set || cmd.do_move;
    cur_waddr  = cmd.do_register ? IDX_W'(count_r) : hole_r;
    cur_wdata  = (cmd.do_register || cmd.do_set) ? {va_r, vbm} : cur_rd;
  end

  ire_ram #(.WIDTH(CNT_W), .DEPTH(KEY_COUNT)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(key_w), .rdata(slot_rd)
  );
  ire_ram #(.WIDTH(EKEY_W), .DEPTH(TABLE_ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(tbl_raddr), .rdata(key_rd)
  );
  ire_ram #(.WIDTH(PAIR_W), .DEPTH(TABLE_ENTRIES)) u_old (
    .clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
    .raddr(tbl_raddr), .rdata(old_rd)
  );
  ire_ram #(.WIDTH(PAIR_W), .DEPTH(TABLE_ENTRIES)) u_cur (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(tbl_raddr), .rdata(cur_rd)
  );

  // Blend: old + floor((cur - old) * frac / 65536), 32-bit wrap.
  assign da = cur_rd[PAIR_W-1:VAL_W] - old_rd[PAIR_W-1:VAL_W];
  assign db = cur_rd[VAL_W-1:0] - old_rd[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa_r <= PROD_W'($signed(da) * $signed({1'b0, frac_r}));
      pb_r <= PROD_W'($signed(db) * $signed({1'b0, frac_r}));
    end
  end

  always_comb begin
    if (enable_r) begin
      res_a = old_rd[PAIR_W-1:VAL_W] + pa_r[VAL_W+FRAC_SH-1:FRAC_SH];
      res_b = old_rd[VAL_W-1:0] + pb_r[VAL_W+FRAC_SH-1:FRAC_SH];
    end else begin
      res_a = cur_rd[PAIR_W-1:VAL_W];
      res_b = cur_rd[VAL_W-1:0];
    end
    if (key_rd[EKEY_W-1:OBJ_W] < KIND_FLOOR_PAN) begin
      res_b = '0;
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_frame || cmd.load_res) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      status_r <= ST_FRAME;
      okind_r  <= key_rd[EKEY_W-1:OBJ_W];
      oobj_r   <= key_rd[OBJ_W-1:0];
      oa_r     <= res_a;
      ob_r     <= res_b;
      olast_r  <= (idx_r == '0);
    end else if (cmd.load_res) begin
      status_r <= cmd.res_status;
      okind_r  <= '0;
      oobj_r   <= '0;
      oa_r     <= '0;
      ob_r     <= '0;
      olast_r  <= 1'b1;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.out_kind   = okind_r;
  assign out_if.out_object = oobj_r;
  assign out_if.interp_a   = oa_r;
  assign out_if.interp_b   = ob_r;
  assign out_if.last       = olast_r;

  assign sts.in_valid  = in_if.valid;
  assign sts.func      = func_r;
  assign sts.key_ok    = key_ok;
  assign sts.hit       = key_ok && slot_ok_r && (key_rd == {kind_r, obj_r});
  assign sts.full      = 32'(count_r) >= TABLE_ENTRIES;
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.move_need = (hole_r != last_idx);
  assign sts.idx_last  = (idx_r == last_idx);
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.out_free  = out_free;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_ENTRIES)
    else $error("entry count above table size");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_frame || cmd.load_res) |-> out_free)
    else $error("result register overwritten");
  a_reg_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_register |-> (32'(count_r) < TABLE_ENTRIES))
    else $error("register into full table");
  a_unreg_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_unreg |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("unregister did not shrink table");
`endif
endmodule

[rtl/interpolation_registry_engine_unit.sv]
// Top level of the interpolation registry engine.
// Depends on ire_pkg, ire_if, ire_ctrl, ire_dp (and ire_ram through ire_dp).
//
//   channel | direction | transaction
//   in_if   | sink      | one operation: func, kind, object_index, value_a, value_b, frac
//   out_if  | source    | one result: status, out_kind, out_object, interp_a, interp_b, last
//   cfg_if  | sink      | write of interp_enable (always ready)
//
// One operation is in flight at a time, sequenced through the single read port of each
// table memory.
// Reset (rst_n low, synchronous) empties the table and sets interp_enable; the slot
// map is never swept: a slot is trusted only when it points below the entry count
// at an entry whose stored key matches, so stale slot contents are harmless.
// Stalls: a held result stalls the next load only; the input is taken again as soon
// as the final result of the previous transaction sits in the output register.
module interpolation_registry_engine_unit (
  input logic       clk,
  input logic       rst_n,
  ire_in_if.sink    in_if,
  ire_out_if.source out_if,
  ire_cfg_if.sink   cfg_if
);
  import ire_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each transaction through lookup, update, sweep or frame walk.
  ire_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .cmd  (cmd)
  );

  // Hold the tables, slot map, blend arithmetic and the result register.
  ire_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );
endmodule

[dv/ire_tb_pkg.sv]
// Shared item and result types for the interpolation registry engine bench.
// Depends on ire_pkg for widths and codes.
package ire_tb_pkg;
  import ire_pkg::*;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic [KIND_W-1:0]       kind;
    logic [OBJ_W-1:0]        obj;
    logic signed [VAL_W-1:0] va;
    logic signed [VAL_W-1:0] vb;
    logic [FRAC_W-1:0]       frac;
  } op_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [KIND_W-1:0]       kind;
    logic [OBJ_W-1:0]        obj;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    last;
  } frame_res_t;

endpackage

[dv/tb_top.sv]
// Self-checking bench for interpolation_registry_engine_unit.
// Depends on ire_pkg, ire_tb_pkg and the channel interfaces in rtl/ire_if.sv.
module tb_top;
  import ire_pkg::*;
  import ire_tb_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int FUNC_BAD = 7;

  logic clk;
  logic rst_n;

  ire_in_if  in_if();
  ire_out_if out_if();
  ire_cfg_if cfg_if();

  interpolation_registry_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  // Shadow of the engine state
  logic [KIND_W-1:0] sh_kind [TABLE_ENTRIES];
  logic [OBJ_W-1:0]  sh_obj  [TABLE_ENTRIES];
  logic [VAL_W-1:0]  sh_old_a[TABLE_ENTRIES];
  logic [VAL_W-1:0]  sh_old_b[TABLE_ENTRIES];
  logic [VAL_W-1:0]  sh_cur_a[TABLE_ENTRIES];
  logic [VAL_W-1:0]  sh_cur_b[TABLE_ENTRIES];
  int                sh_count;
  bit                sh_enable;

  frame_res_t expected_results[$];
  int  errors;
  int  idle_cycles;
  int  n_ops;
  int  n_results;
  int  n_frames;

  // Table of directed stimulus with optional typed-in results
  typedef struct {
    op_item_t   op;
    bit         has_exp;
    frame_res_t exp;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Blend old toward cur by frac in 1.16, wrapping at 32 bits
  function automatic logic [VAL_W-1:0] blend_value(logic [VAL_W-1:0] oldv,
                                                   logic [VAL_W-1:0] curv,
                                                   logic [FRAC_W-1:0] fr);
    logic signed [VAL_W-1:0] diff;
    logic signed [63:0]      prod;
    diff = curv - oldv;
    prod = 64'(diff) * $signed({47'd0, fr});
    return oldv + VAL_W'(prod >>> FRAC_SH);
  endfunction

  function automatic int find_entry(logic [KIND_W-1:0] k, logic [OBJ_W-1:0] o);
    for (int i = 0; i < sh_count; i++)
      if (sh_kind[i] == k && sh_obj[i] == o) return i;
    return -1;
  endfunction

  function automatic frame_res_t status_only(res_t st);
    frame_res_t r;
    r.status = st; r.kind = '0; r.obj = '0; r.a = '0; r.b = '0; r.last = 1'b1;
    return r;
  endfunction

  // Advance the shadow by one operation and queue what it produces
  task automatic predict_operation(input op_item_t op);
    logic [FRAC_W-1:0] fr;
    frame_res_t        r;
    int                idx;
    bit                key_ok;
    fr = (op.frac > FRAC_ONE) ? FRAC_W'(FRAC_ONE) : op.frac;
    key_ok = op.kind < KIND_COUNT;
    idx = key_ok ? find_entry(op.kind, op.obj) : -1;
    case (op.func)
      FN_REGISTER: begin
        if (!key_ok || idx >= 0) expected_results.push_back(status_only(ST_IGNORED));
        else if (sh_count >= TABLE_ENTRIES) expected_results.push_back(status_only(ST_FULL));
        else begin
          sh_kind[sh_count] = op.kind;
          sh_obj[sh_count] = op.obj;
          sh_old_a[sh_count] = op.va;
          sh_cur_a[sh_count] = op.va;
          sh_old_b[sh_count] = (op.kind >= KIND_FLOOR_PAN) ? op.vb : '0;
          sh_cur_b[sh_count] = sh_old_b[sh_count];
          sh_count++;
          expected_results.push_back(status_only(ST_DONE));
        end
      end
      FN_UNREGISTER: begin
        if (idx < 0) expected_results.push_back(status_only(ST_IGNORED));
        else begin
          sh_count--;
          // move the last entry into the hole
          sh_kind[idx] = sh_kind[sh_count];
          sh_obj[idx] = sh_obj[sh_count];
          sh_old_a[idx] = sh_old_a[sh_count];
          sh_old_b[idx] = sh_old_b[sh_count];
          sh_cur_a[idx] = sh_cur_a[sh_count];
          sh_cur_b[idx] = sh_cur_b[sh_count];
          expected_results.push_back(status_only(ST_DONE));
        end
      end
      FN_SET_CURRENT: begin
        if (idx < 0) expected_results.push_back(status_only(ST_IGNORED));
        else begin
          sh_cur_a[idx] = op.va;
          sh_cur_b[idx] = (op.kind >= KIND_FLOOR_PAN) ? op.vb : '0;
          expected_results.push_back(status_only(ST_DONE));
        end
      end
      FN_TICK_CAPTURE: begin
        for (int i = 0; i < sh_count; i++) begin
          sh_old_a[i] = sh_cur_a[i];
          sh_old_b[i] = sh_cur_b[i];
        end
        expected_results.push_back(status_only(ST_DONE));
      end
      FN_RENDER_FRAME: begin
        if (sh_count == 0) expected_results.push_back(status_only(ST_EMPTY));
        for (int i = sh_count - 1; i >= 0; i--) begin
          r.status = ST_FRAME;
          r.kind = sh_kind[i];
          r.obj = sh_obj[i];
          r.a = sh_enable ? blend_value(sh_old_a[i], sh_cur_a[i], fr) : sh_cur_a[i];
          r.b = sh_enable ? blend_value(sh_old_b[i], sh_cur_b[i], fr) : sh_cur_b[i];
          if (sh_kind[i] < KIND_FLOOR_PAN) r.b = '0;
          r.last = (i == 0);
          expected_results.push_back(r);
        end
      end
      default: expected_results.push_back(status_only(ST_IGNORED));
    endcase
  endtask

  // Drive one transaction after a random gap; inputs move on the falling edge
  task automatic send_operation(input op_item_t op);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func <= op.func;
    in_if.kind <= op.kind;
    in_if.object_index <= op.obj;
    in_if.value_a <= op.va;
    in_if.value_b <= op.vb;
    in_if.frac <= op.frac;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_operation(op);
    n_ops++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    // a non-result operation cannot be pending here, but let the pipeline settle
    repeat (8) @(negedge clk);
  endtask

  task automatic write_enable(input bit en);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.interp_enable <= en;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sh_enable = en;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic op_item_t make_op(int f, int k, int o, logic [31:0] a,
                                       logic [31:0] b, int fr);
    op_item_t op;
    op.func = FUNC_W'(f); op.kind = KIND_W'(k); op.obj = OBJ_W'(o);
    op.va = a; op.vb = b; op.frac = FRAC_W'(fr);
    return op;
  endfunction

  // Random op biased toward a small key pool so most operations hit entries
  function automatic op_item_t random_op();
    op_item_t op;
    int sel;
    sel = $urandom_range(0, 99);
    op.kind = (sel < 95) ? KIND_W'($urandom_range(0, KIND_COUNT - 1)) : KIND_W'($urandom);
    op.obj = ($urandom_range(0, 9) < 8) ? OBJ_W'($urandom_range(0, 11)) : OBJ_W'($urandom);
    op.va = $urandom;
    op.vb = $urandom;
    op.frac = ($urandom_range(0, 9) == 0) ? FRAC_W'($urandom) :
              FRAC_W'($urandom_range(0, FRAC_ONE));
    sel = $urandom_range(0, 99);
    if (sel < 30) op.func = FN_REGISTER;
    else if (sel < 45) op.func = FN_UNREGISTER;
    else if (sel < 70) op.func = FN_SET_CURRENT;
    else if (sel < 82) op.func = FN_TICK_CAPTURE;
    else if (sel < 97) op.func = FN_RENDER_FRAME;
    else op.func = FUNC_W'($urandom_range(5, FUNC_BAD));
    return op;
  endfunction

  // Result side: random stalls, compare against the oldest expectation
  initial begin
    int stall;
    frame_res_t e;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d a=%h", $time, out_if.status,
                 out_if.interp_a);
      end else begin
        e = expected_results.pop_front();
        if (out_if.status != e.status || out_if.out_kind != e.kind ||
            out_if.out_object != e.obj || out_if.interp_a != e.a ||
            out_if.interp_b != e.b || out_if.last != e.last) begin
          errors++;
          $display("%0t: mismatch expected st=%0d k=%0d o=%0d a=%h b=%h l=%0b",
                   $time, e.status, e.kind, e.obj, e.a, e.b, e.last);
          $display("%0t:          actual   st=%0d k=%0d o=%0d a=%h b=%h l=%0b",
                   $time, out_if.status, out_if.out_kind, out_if.out_object,
                   out_if.interp_a, out_if.interp_b, out_if.last);
        end
        if (e.status == ST_FRAME && e.last) n_frames++;
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles with no accepted transaction on any channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Main stimulus
  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    op_item_t op;
    frame_res_t chk;
    int n_random;
    errors = 0; n_ops = 0; n_results = 0; n_frames = 0;
    sh_count = 0; sh_enable = 1'b1;
    in_if.valid = 1'b0; in_if.func = '0; in_if.kind = '0; in_if.object_index = '0;
    in_if.value_a = '0; in_if.value_b = '0; in_if.frac = '0;
    cfg_if.valid = 1'b0; cfg_if.interp_enable = 1'b1;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: typed-in results only where they are obvious
    row.has_exp = 1'b1;
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 0);
    row.exp = status_only(ST_EMPTY); rows.push_back(row);
    row.op = make_op(FN_UNREGISTER, 1, 5, 0, 0, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.op = make_op(FN_SET_CURRENT, 2, 5, 1, 1, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.op = make_op(FN_REGISTER, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    row.exp = status_only(ST_DONE); rows.push_back(row);
    row.op = make_op(FN_REGISTER, 0, 0, 5, 5, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.op = make_op(FN_REGISTER, 5, 1, 5, 5, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.op = make_op(FN_REGISTER, 7, 4095, 5, 5, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.op = make_op(6, 0, 0, 0, 0, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.op = make_op(5, 2, 3, 0, 0, 0);
    row.exp = status_only(ST_IGNORED); rows.push_back(row);
    row.has_exp = 1'b0;
    row.op = make_op(FN_REGISTER, 4, 4095, 32'h7FFF_FFFF, 32'h8000_0000, 0); rows.push_back(row);
    row.op = make_op(FN_REGISTER, 1, 7, 32'h0001_0000, 0, 0); rows.push_back(row);
    row.op = make_op(FN_REGISTER, 3, 2048, 32'hFFFF_0000, 32'h0000_FFFF, 0); rows.push_back(row);
    row.op = make_op(FN_SET_CURRENT, 4, 4095, 32'h8000_0000, 32'h7FFF_FFFF, 0); rows.push_back(row);
    row.op = make_op(FN_SET_CURRENT, 0, 0, 32'h7FFF_FFFF, 32'h1234_5678, 0); rows.push_back(row);
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 0); rows.push_back(row);
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 65536); rows.push_back(row);
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 32768); rows.push_back(row);
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 131071); rows.push_back(row);
    row.op = make_op(FN_TICK_CAPTURE, 0, 0, 0, 0, 0); rows.push_back(row);
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 12345); rows.push_back(row);
    row.op = make_op(FN_UNREGISTER, 0, 0, 0, 0, 0); rows.push_back(row);
    row.op = make_op(FN_UNREGISTER, 3, 2048, 0, 0, 0); rows.push_back(row);
    row.op = make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 40000); rows.push_back(row);

    foreach (rows[i]) begin
      send_operation(rows[i].op);
      if (rows[i].has_exp) begin
        chk = expected_results[expected_results.size() - 1];
        if (chk != rows[i].exp) begin
          errors++;
          $display("%0t: row %0d expected status %0d, predictor gave %0d", $time, i,
                   rows[i].exp.status, chk.status);
        end
      end
    end

    // Fill the table to its limit to reach the full status, then frame it
    write_enable(1'b0);
    for (int i = sh_count; i < TABLE_ENTRIES + 2; i++)
      send_operation(make_op(FN_REGISTER, i % KIND_COUNT, 100 + i, $urandom, $urandom, 0));
    send_operation(make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 20000));
    write_enable(1'b1);
    send_operation(make_op(FN_TICK_CAPTURE, 0, 0, 0, 0, 0));
    send_operation(make_op(FN_RENDER_FRAME, 0, 0, 0, 0, 65536));
    // Drain part of it again, moving the last entry into each hole
    while (sh_count > 44)
      send_operation(make_op(FN_UNREGISTER, sh_kind[0], sh_obj[0], 0, 0, 0));

    // Random phase, with the enable switched off and back on partway
    n_random = 0;
    while (n_random < 16) begin
      op = random_op();
      send_operation(op);
      n_random++;
      if (n_random == 6) write_enable(1'b0);
      if (n_random == 11) write_enable(1'b1);
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Covered %0d operations, %0d results, %0d frames, table fill and both modes.",
             n_ops, n_results, n_frames);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ire_pkg.sv
rtl/ire_if.sv
rtl/ire_ram.sv
rtl/ire_ctrl.sv
rtl/ire_dp.sv
rtl/interpolation_registry_engine_unit.sv
dv/ire_tb_pkg.sv
dv/tb_top.sv
